// File: hdl/dtld_pkg.sv
// Package for the dual tank level debounce block.
// Holds the payload structs, configuration types and reset constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dtld_pkg;

  // Counter widths of the product (room) tank and the drain tank probes.
  localparam int unsigned RoomCntW  = 10;
  localparam int unsigned DrainCntW = 8;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  // Reset values of the hold times.
  localparam logic [RoomCntW-1:0]  RoomResetTicks      = RoomCntW'(20);
  localparam logic [DrainCntW-1:0] DrainResetTicks     = DrainCntW'(20);
  localparam logic [DrainCntW-1:0] DrainLongResetTicks = DrainCntW'(50);

  typedef enum logic [CfgIdxW-1:0] {
    CfgRoomDetect   = 2'd0,
    CfgDrainLow     = 2'd1,
    CfgDrainHighSht = 2'd2,
    CfgDrainHighLng = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic room_low_probe;
    logic room_high_probe;
    logic drain_low_probe;
    logic drain_high_probe;
    logic long_filter_select;
  } in_t;

  typedef struct packed {
    logic [1:0] room_level;
    logic [1:0] drain_level;
    logic       drain_changed;
  } out_t;

  typedef struct packed {
    logic [RoomCntW-1:0]  room_detect_ticks;
    logic [DrainCntW-1:0] drain_low_detect_ticks;
    logic [DrainCntW-1:0] drain_high_short_ticks;
    logic [DrainCntW-1:0] drain_high_long_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// File: hdl/dual_tank_level_debounce_unit.sv
// Dual tank level debounce unit: four float-switch debounce channels, level decode.
// Depends on dtld_pkg, dtld_cfg and dtld_chan.
//
// Usage: every transfer on the input channel is one sampling tick carrying the four
// raw probe bits and the long filter select for the drain high probe. Each tick
// yields exactly one result transfer with the room level, the drain level and a
// pulse that is set when either drain qualified flag changed on that tick.
// The counters and flags are updated at the edge that accepts the tick, and the
// result sits in an output register, so the result is offered in the cycle after the
// input transfer. A new tick is accepted in every cycle while the result register
// is empty or is being emptied in the same cycle, giving one tick per cycle.
// When the receiver stalls, the result register holds its contents and the input
// ready drops until it is taken; no tick is lost or repeated.
// The configuration channel is always ready and writes one of the four hold-time
// registers per transfer; it is meant to be used while no tick is in flight.
// Reset clears all run counters and qualified flags, empties the result register
// and loads the hold times with 20, 20, 20 and 50 ticks.
`default_nettype none

module dual_tank_level_debounce_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dtld_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dtld_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dtld_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dtld_pkg::CfgDataW-1:0] cfg_data_i
);
  import dtld_pkg::*;

  cfg_t            cfg;
  logic            in_fire;
  logic [DrainCntW-1:0] high_limit;
  logic [3:0]      flag_d;
  logic [3:0]      flag_q;
  out_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;

  // Configuration writes never stall.
  assign cfg_ready_o = 1'b1;

  dtld_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The input side advances whenever the result register can take a new result.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign high_limit = in_data_i.long_filter_select ? cfg.drain_high_long_ticks
                                                   : cfg.drain_high_short_ticks;

  dtld_chan #(.CntW(RoomCntW)) u_room_low (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (in_fire),
    .probe_i  (in_data_i.room_low_probe),
    .limit_i  (cfg.room_detect_ticks),
    .flag_d_o (flag_d[0]),
    .flag_q_o (flag_q[0])
  );

  dtld_chan #(.CntW(RoomCntW)) u_room_high (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (in_fire),
    .probe_i  (in_data_i.room_high_probe),
    .limit_i  (cfg.room_detect_ticks),
    .flag_d_o (flag_d[1]),
    .flag_q_o (flag_q[1])
  );

  dtld_chan #(.CntW(DrainCntW)) u_drain_low (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (in_fire),
    .probe_i  (in_data_i.drain_low_probe),
    .limit_i  (cfg.drain_low_detect_ticks),
    .flag_d_o (flag_d[2]),
    .flag_q_o (flag_q[2])
  );

  dtld_chan #(.CntW(DrainCntW)) u_drain_high (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (in_fire),
    .probe_i  (in_data_i.drain_high_probe),
    .limit_i  (high_limit),
    .flag_d_o (flag_d[3]),
    .flag_q_o (flag_q[3])
  );

  // The level code is simply {high flag, low flag}: low, mid, error, full.
  always_comb begin
    out_d.room_level    = flag_d[1:0];
    out_d.drain_level   = flag_d[3:2];
    out_d.drain_changed = (flag_d[3:2] != flag_q[3:2]);
    out_valid_d         = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register, loaded only when a tick is accepted.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An accepted tick always leaves a result waiting in the next cycle.
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted tick produced no result");

  // Input only stalls when a result is stuck at the receiver.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked result");

  // The drain change pulse must match a move of the registered drain flags.
  a_drain_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (out_data_o.drain_changed == (flag_q[3:2] != $past(flag_q[3:2]))))
    else $error("drain change pulse does not match drain flag update");

  // With a zero room hold time the room flags follow the probes on the same tick.
  a_room_zero_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cfg.room_detect_ticks == '0)) |=>
      (out_data_o.room_level ==
       $past({in_data_i.room_high_probe, in_data_i.room_low_probe})))
    else $error("room level did not follow probes at zero hold time");

endmodule

`default_nettype wire

// File: hdl/dtld_cfg.sv
// Configuration register file of the dual tank level debounce block.
// Holds the four hold-time registers; depends on dtld_pkg.
`default_nettype none

module dtld_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [dtld_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dtld_pkg::CfgDataW-1:0]   cfg_data_i,
  output dtld_pkg::cfg_t                  cfg_o
);
  import dtld_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgRoomDetect:   cfg_d.room_detect_ticks      = cfg_data_i[RoomCntW-1:0];
        CfgDrainLow:     cfg_d.drain_low_detect_ticks = cfg_data_i[DrainCntW-1:0];
        CfgDrainHighSht: cfg_d.drain_high_short_ticks = cfg_data_i[DrainCntW-1:0];
        CfgDrainHighLng: cfg_d.drain_high_long_ticks  = cfg_data_i[DrainCntW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.room_detect_ticks      <= RoomResetTicks;
      cfg_q.drain_low_detect_ticks <= DrainResetTicks;
      cfg_q.drain_high_short_ticks <= DrainResetTicks;
      cfg_q.drain_high_long_ticks  <= DrainLongResetTicks;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hdl/dtld_chan.sv
// One probe debounce channel: on and off run counters plus the qualified flag.
// Depends on dtld_pkg for the default counter width.
`default_nettype none

module dtld_chan #(
  parameter int unsigned CntW = dtld_pkg::DrainCntW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tick_i,
  input  logic            probe_i,
  input  logic [CntW-1:0] limit_i,
  output logic            flag_d_o,
  output logic            flag_q_o
);
  import dtld_pkg::*;

  logic [CntW-1:0] on_cnt_q, on_cnt_d;
  logic [CntW-1:0] off_cnt_q, off_cnt_d;
  logic            flag_q, flag_d;
  logic [CntW-1:0] run_cnt;
  logic [CntW:0]   run_next;
  logic [CntW-1:0] run_upd;

  // The increment is one bit wider so a maximal limit saturates instead of wrapping.
  always_comb begin
    run_cnt  = probe_i ? on_cnt_q : off_cnt_q;
    run_next = {1'b0, run_cnt} + {{CntW{1'b0}}, 1'b1};
    flag_d   = flag_q;
    if (run_next >= {1'b0, limit_i}) begin
      run_upd = limit_i;
      flag_d  = probe_i;
    end else begin
      run_upd = run_next[CntW-1:0];
    end
    on_cnt_d  = probe_i ? run_upd : '0;
    off_cnt_d = probe_i ? '0 : run_upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_cnt_q  <= '0;
      off_cnt_q <= '0;
      flag_q    <= 1'b0;
    end else if (tick_i) begin
      on_cnt_q  <= on_cnt_d;
      off_cnt_q <= off_cnt_d;
      flag_q    <= flag_d;
    end
  end

  assign flag_d_o = flag_d;
  assign flag_q_o = flag_q;

endmodule

`default_nettype wire

// File: tb/sv/dual_tank_level_debounce_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for dual_tank_level_debounce_unit: random probe runs with a
// bit-accurate level predictor and in-order result checking.
// Depends on dtld_pkg and the dual_tank_level_debounce_unit RTL.

module dual_tank_level_debounce_unit_tb;
  import dtld_pkg::*;

  // Clock, reset and the signals seen by the block. Every input starts at a known value.
  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = CfgRoomDetect;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // Ticks waiting to be offered, and level results waiting to arrive, oldest first.
  in_t  tick_queue [$];
  out_t level_expect [$];

  // Predictor state: one on and one off run counter per probe, the four qualified flags
  // (bit 0 room low, bit 1 room high, bit 2 drain low, bit 3 drain high) and the hold
  // times. The drain counters never pass 255, so the room width holds all of them.
  logic [RoomCntW-1:0] on_run  [4];
  logic [RoomCntW-1:0] off_run [4];
  logic [3:0]          level_flags;
  cfg_t                hold_cfg;

  // Run control shared by the stimulus process and the two handshake processes.
  bit          idle_en = 1'b1;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold_left = 0;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  out_t        want;

  dual_tank_level_debounce_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous fixed bound on the whole run; a hung handshake ends up here.
  initial begin
    #4_000_000;
    $display("dual_tank_level_debounce_unit: mismatch");
    $finish;
  end

  function automatic in_t make_tick(input logic room_low, input logic room_high,
                                    input logic drain_low, input logic drain_high,
                                    input logic long_sel);
    in_t tick;
    tick.room_low_probe     = room_low;
    tick.room_high_probe    = room_high;
    tick.drain_low_probe    = drain_low;
    tick.drain_high_probe   = drain_high;
    tick.long_filter_select = long_sel;
    return tick;
  endfunction

  // Advances the debounce state by one tick and returns the level result it produces.
  // The running counter is bumped one bit wider than its storage, so a counter that
  // sits at the largest hold time saturates there instead of wrapping, and a counter
  // that stands above a newly shortened hold time is pulled back down to it.
  function automatic out_t advance_levels(input in_t tick);
    logic [3:0]          probe;
    logic [RoomCntW-1:0] limit [4];
    logic [RoomCntW:0]   nxt;
    logic [1:0]          drain_before;
    out_t                res;
    probe = {tick.drain_high_probe, tick.drain_low_probe,
             tick.room_high_probe, tick.room_low_probe};
    limit[0] = hold_cfg.room_detect_ticks;
    limit[1] = hold_cfg.room_detect_ticks;
    limit[2] = RoomCntW'(hold_cfg.drain_low_detect_ticks);
    limit[3] = tick.long_filter_select ? RoomCntW'(hold_cfg.drain_high_long_ticks)
                                       : RoomCntW'(hold_cfg.drain_high_short_ticks);
    drain_before = level_flags[3:2];
    for (int p = 0; p < 4; p++) begin
      if (probe[p]) begin
        nxt = {1'b0, on_run[p]} + 1'b1;
        off_run[p] = '0;
      end else begin
        nxt = {1'b0, off_run[p]} + 1'b1;
        on_run[p] = '0;
      end
      if (nxt >= {1'b0, limit[p]}) begin
        nxt = {1'b0, limit[p]};
        level_flags[p] = probe[p];
      end
      if (probe[p]) begin
        on_run[p] = nxt[RoomCntW-1:0];
      end else begin
        off_run[p] = nxt[RoomCntW-1:0];
      end
    end
    res.room_level    = level_flags[1:0];
    res.drain_level   = level_flags[3:2];
    res.drain_changed = (level_flags[3:2] != drain_before);
    return res;
  endfunction

  // Mirrors one register write; the drain registers keep only their low eight bits.
  function automatic void apply_hold_time(input cfg_idx_e idx,
                                          input logic [CfgDataW-1:0] value);
    case (idx)
      CfgRoomDetect:   hold_cfg.room_detect_ticks      = value;
      CfgDrainLow:     hold_cfg.drain_low_detect_ticks = value[DrainCntW-1:0];
      CfgDrainHighSht: hold_cfg.drain_high_short_ticks = value[DrainCntW-1:0];
      CfgDrainHighLng: hold_cfg.drain_high_long_ticks  = value[DrainCntW-1:0];
      default: ;
    endcase
  endfunction

  // Returns once every queued tick has been taken and every result has arrived.
  // This is also where the sender pauses.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || level_expect.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Writes all four hold times back to back while the block is idle. Valid stays high
  // across the transfers; only the index and data move on after each accepted write.
  task automatic write_hold_times(input logic [CfgDataW-1:0] room,
                                  input logic [CfgDataW-1:0] drain_low,
                                  input logic [CfgDataW-1:0] drain_short,
                                  input logic [CfgDataW-1:0] drain_long);
    cfg_idx_e            idx [4];
    logic [CfgDataW-1:0] val [4];
    int                  k;
    idx = '{CfgRoomDetect, CfgDrainLow, CfgDrainHighSht, CfgDrainHighLng};
    val = '{room, drain_low, drain_short, drain_long};
    k = 0;
    wait_for_drain();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx[0];
    cfg_data  <= val[0];
    while (k < 4) begin
      @(posedge clk);
      if (cfg_ready) begin
        apply_hold_time(idx[k], val[k]);
        k++;
        if (k < 4) begin
          cfg_index <= idx[k];
          cfg_data  <= val[k];
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
    @(negedge clk);
  endtask

  // Queues ticks in which each probe holds its level for a random run of 1 to max_run
  // ticks, so that most runs get past the hold time, with single-tick glitches mixed in
  // at noise_pct percent. With hold_room set both room probes sit at the opposite of
  // their current flags for the whole stretch, so the room counters climb as far as
  // the ticks allow. The long filter select toggles now and then, also in mid-run.
  task automatic queue_ticks(input int count, input int max_run, input int noise_pct,
                             input bit hold_room);
    logic [3:0] level;
    logic [3:0] val;
    logic [1:0] room_hold;
    logic       long_sel;
    int         left [4];
    room_hold = ~level_flags[1:0];
    long_sel  = 1'($urandom_range(0, 1));
    for (int p = 0; p < 4; p++) begin
      left[p]  = 0;
      level[p] = 1'b0;
    end
    for (int n = 0; n < count; n++) begin
      for (int p = 0; p < 4; p++) begin
        if (left[p] == 0) begin
          level[p] = 1'($urandom_range(0, 1));
          left[p]  = $urandom_range(1, max_run);
        end
        left[p]--;
        val[p] = level[p];
        if ($urandom_range(0, 99) < noise_pct) val[p] = ~val[p];
      end
      if (hold_room) val[1:0] = room_hold;
      if ($urandom_range(0, 7) == 0) long_sel = ~long_sel;
      tick_queue.push_back(make_tick(val[0], val[1], val[2], val[3], long_sel));
    end
  endtask

  // Input driver. A tick is predicted at the edge that completes its transfer. A new
  // tick, or an idle burst, is chosen only when no transfer is pending, so valid and
  // the payload stay put until the block takes them.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) level_expect.push_back(advance_levels(in_data));
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
          tx_gap = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else begin
          in_data  <= tick_queue.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Long receiver hold-off, counted here in cycles once the stimulus asks for one.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rx_hold_left <= 0;
    end else if (rx_hold_req != 0) begin
      rx_hold_left <= rx_hold_req;
      rx_hold_req = 0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Result monitor. Each result transfer is compared field by field with the oldest
  // prediction; ready then follows the hold-off and random idle bursts.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (level_expect.size() == 0) begin
          if (mismatch_count < 10) $display("result %0d with nothing expected: %p",
                                            result_count, out_data);
          mismatch_count++;
        end else begin
          want = level_expect.pop_front();
          if (out_data.room_level !== want.room_level ||
              out_data.drain_level !== want.drain_level ||
              out_data.drain_changed !== want.drain_changed) begin
            if (mismatch_count < 10)
              $display("result %0d: expected room %0d drain %0d changed %0b, got %0d %0d %0b",
                       result_count, want.room_level, want.drain_level, want.drain_changed,
                       out_data.room_level, out_data.drain_level, out_data.drain_changed);
            mismatch_count++;
          end
        end
        result_count++;
      end
      if (rx_hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    hold_cfg    = '{RoomResetTicks, DrainResetTicks, DrainResetTicks, DrainLongResetTicks};
    level_flags = '0;
    for (int p = 0; p < 4; p++) begin
      on_run[p]  = '0;
      off_run[p] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset hold times: all four flags qualify on the twentieth steady tick.
    for (int n = 0; n < 20; n++) begin
      tick_queue.push_back(make_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
    end

    // Zero hold times: each flag follows its probe on the same tick, walking both tanks
    // through full, error (high without low), mid and empty.
    write_hold_times(10'd0, 10'd0, 10'd0, 10'd0);
    tick_queue.push_back(make_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    tick_queue.push_back(make_tick(1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
    tick_queue.push_back(make_tick(1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
    tick_queue.push_back(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));

    // Drain high counts toward the long time, then the short time is selected while the
    // counter already stands above it: the counter is clamped and the flag follows.
    write_hold_times(10'd1, 10'd3, 10'd2, 10'd6);
    for (int n = 0; n < 4; n++) begin
      tick_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b1));
    end
    tick_queue.push_back(make_tick(1'b1, 1'b0, 1'b0, 1'b1, 1'b0));

    // Moderate hold times, long mostly above short so mid-run select changes clamp often.
    write_hold_times(CfgDataW'($urandom_range(3, 30)), CfgDataW'($urandom_range(3, 30)),
                     CfgDataW'($urandom_range(0, 15)), CfgDataW'($urandom_range(10, 40)));
    queue_ticks(150, 40, 5, 1'b0);

    // Long room hold time past the eight-bit range: the room probes stay steady long
    // enough to saturate at 380. The receiver stalls for a long stretch at the start,
    // which holds off the input while ticks wait in the queue.
    write_hold_times(10'd380, CfgDataW'($urandom_range(0, 12)),
                     CfgDataW'($urandom_range(0, 12)), CfgDataW'($urandom_range(0, 12)));
    rx_hold_req = 150;
    queue_ticks(390, 20, 3, 1'b1);

    // Largest drain hold times; the short and long ones are written with unused upper data bits set.
    write_hold_times(10'd8, 10'h0FF, 10'h3FF, 10'h1FF);
    queue_ticks(280, 280, 2, 1'b0);

    // Random small hold times with junk in the upper drain bits, and heavy noise.
    write_hold_times(CfgDataW'($urandom_range(0, 20)),
                     {2'($urandom_range(0, 3)), 8'($urandom_range(0, 20))},
                     {2'($urandom_range(0, 3)), 8'($urandom_range(0, 20))},
                     {2'($urandom_range(0, 3)), 8'($urandom_range(0, 20))});
    queue_ticks(120, 8, 50, 1'b0);

    // Back-to-back transfers with no idling: zero short time against a long time of 255.
    write_hold_times(10'd0, 10'd1, 10'd0, 10'd255);
    idle_en = 1'b0;
    queue_ticks(80, 6, 10, 1'b0);

    wait_for_drain();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && level_expect.size() == 0) begin
      $display("dual_tank_level_debounce_unit: match");
    end else begin
      $display("dual_tank_level_debounce_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: dual_tank_level_debounce_unit.f
hdl/dtld_pkg.sv
hdl/dtld_cfg.sv
hdl/dtld_chan.sv
hdl/dual_tank_level_debounce_unit.sv
tb/sv/dual_tank_level_debounce_unit_tb.sv
